// ===== src/upta_pkg.sv =====
`timescale 1ns / 1ps

package upta_pkg;

    localparam int FIELD_BITS     = 32;
    localparam int CFG_INDEX_BITS = 2;

    // Commands
    localparam logic [1:0] CMD_RUN       = 2'd0;
    localparam logic [1:0] CMD_NEXT_UNIT = 2'd1;
    localparam logic [1:0] CMD_TIME_ZERO = 2'd2;

    // Servant kinds; the unused code behaves as an output servant
    localparam logic [1:0] KIND_INPUT   = 2'd0;
    localparam logic [1:0] KIND_COMPUTE = 2'd1;
    localparam logic [1:0] KIND_OUTPUT  = 2'd2;

    // Register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNIT_LENGTH     = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_INPUT_DURATION  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_OUTPUT_DURATION = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MODE_PERIOD     = 2'd3;

    localparam logic [FIELD_BITS-1:0] UNIT_LENGTH_RESET = 32'd1;

    typedef struct packed {
        logic [1:0]            command;
        logic [1:0]            servant_kind;
        logic [FIELD_BITS-1:0] exec_ticks;
        logic [FIELD_BITS-1:0] task_period;
    } in_item_t;

    typedef struct packed {
        logic                  released;
        logic [FIELD_BITS-1:0] release_time;
        logic [FIELD_BITS-1:0] time_now;
        logic                  mode_end;
        logic                  period_start;
    } out_item_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] unit_length;
        logic [FIELD_BITS-1:0] input_duration;
        logic [FIELD_BITS-1:0] output_duration;
        logic [FIELD_BITS-1:0] mode_period;
    } cfg_t;

endpackage

// ===== src/upta_rem_serial.sv =====
`timescale 1ns / 1ps

module upta_rem_serial #(
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] num,
    input  logic [WIDTH-1:0] den,
    output logic             done,
    output logic [WIDTH-1:0] rem
);

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic             active_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [WIDTH-1:0] num_reg;
    logic [WIDTH-1:0] den_reg;
    logic [WIDTH-1:0] rem_reg;

    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   diff;
    logic             fits;
    logic [WIDTH-1:0] rem_step;

    // Restoring step: bring in the next dividend bit, subtract where it fits
    always_comb
    begin
        trial    = {rem_reg, num_reg[WIDTH-1]};
        fits     = trial >= {1'b0, den_reg};
        diff     = trial - {1'b0, den_reg};
        rem_step = fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                active_reg <= 1'b1;
                cnt_reg    <= CNT_W'(WIDTH);
                num_reg    <= num;
                den_reg    <= den;
                rem_reg    <= '0;
            end
            else if (active_reg)
            begin
                rem_reg <= rem_step;
                num_reg <= {num_reg[WIDTH-2:0], 1'b0};
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !active_reg)
        else $error("remainder unit restarted mid-run");

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> rem_reg < den_reg)
        else $error("remainder not below divisor");

    a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(active_reg))
        else $error("done without a run");

endmodule

// ===== src/upta_core.sv =====
`timescale 1ns / 1ps

module upta_core #(
    parameter int TICK_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  upta_pkg::in_item_t   item,
    input  upta_pkg::cfg_t       cfg,
    output logic                 idle,
    output logic                 res_valid,
    output upta_pkg::out_item_t  res,
    input  logic                 res_take
);

    localparam int W  = TICK_BITS;
    localparam int FB = upta_pkg::FIELD_BITS;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_UB_GO,
        S_UB_WAIT,
        S_CS,
        S_OB,
        S_RAISE,
        S_NEXT,
        S_FIT,
        S_UE,
        S_UE_GO,
        S_UE_WAIT,
        S_REL,
        S_PER_GO,
        S_PER_WAIT,
        S_DONE
    } state_t;

    state_t       state_reg;
    logic [W-1:0] time_reg;
    logic [W-1:0] aux_reg;
    logic [W-1:0] rel_reg;
    logic [W-1:0] wcet_reg;
    logic [W-1:0] per_reg;
    logic [W-1:0] ulen_reg;
    logic [W-1:0] span_reg;
    logic [1:0]   cmd_reg;
    logic [1:0]   kind_reg;
    logic         ok_reg;
    logic         ps_reg;
    logic         pass_reg;
    logic         div_start_reg;
    logic [W-1:0] div_num_reg;
    logic [W-1:0] div_den_reg;

    logic         div_done;
    logic [W-1:0] div_rem;
    logic [W-1:0] ulen_cfg;
    logic [W-1:0] fit_sum;
    logic         is_compute;

    upta_rem_serial #(
        .WIDTH (W)
    ) u_rem (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (div_num_reg),
        .den   (div_den_reg),
        .done  (div_done),
        .rem   (div_rem)
    );

    always_comb
    begin
        ulen_cfg   = (W'(cfg.unit_length) == '0) ? W'(1) : W'(cfg.unit_length);
        fit_sum    = time_reg + wcet_reg;
        is_compute = kind_reg == upta_pkg::KIND_COMPUTE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            time_reg      <= '0;
            div_start_reg <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg  <= item.command;
                        kind_reg <= item.servant_kind;
                        wcet_reg <= W'(item.exec_ticks);
                        per_reg  <= W'(item.task_period);
                        ok_reg   <= 1'b0;
                        rel_reg  <= '0;
                        ps_reg   <= 1'b0;
                        pass_reg <= 1'b0;
                        unique case (item.command)
                            upta_pkg::CMD_RUN:
                                state_reg <= (item.servant_kind == upta_pkg::KIND_INPUT)
                                             ? S_REL : S_PREP;
                            upta_pkg::CMD_NEXT_UNIT:
                                state_reg <= S_PREP;
                            upta_pkg::CMD_TIME_ZERO:
                            begin
                                time_reg  <= '0;
                                state_reg <= S_PER_GO;
                            end
                            default:
                                state_reg <= S_PER_GO;
                        endcase
                    end
                end
                S_PREP:
                begin
                    ulen_reg  <= ulen_cfg;
                    span_reg  <= ulen_cfg - W'(cfg.output_duration);
                    state_reg <= S_UB_GO;
                end
                S_UB_GO:
                begin
                    div_start_reg <= 1'b1;
                    div_num_reg   <= time_reg - W'(1);
                    div_den_reg   <= ulen_reg;
                    state_reg     <= S_UB_WAIT;
                end
                S_UB_WAIT:
                begin
                    if (div_done)
                    begin
                        // unit start: t - rem - 1, held at zero for time zero
                        aux_reg <= (time_reg == '0) ? '0 : time_reg + ~div_rem;
                        priority if (cmd_reg == upta_pkg::CMD_NEXT_UNIT)
                            state_reg <= S_NEXT;
                        else if (is_compute)
                            state_reg <= pass_reg ? S_OB : S_CS;
                        else
                            state_reg <= pass_reg ? S_UE : S_OB;
                    end
                end
                S_CS:
                begin
                    aux_reg   <= aux_reg + W'(cfg.input_duration);
                    state_reg <= S_RAISE;
                end
                S_OB:
                begin
                    aux_reg   <= aux_reg + span_reg;
                    state_reg <= is_compute ? S_FIT : S_RAISE;
                end
                S_RAISE:
                begin
                    // raise time to the phase start, then recompute the unit
                    if (time_reg < aux_reg)
                        time_reg <= aux_reg;
                    pass_reg  <= 1'b1;
                    state_reg <= S_UB_GO;
                end
                S_NEXT:
                begin
                    time_reg  <= aux_reg + ulen_reg;
                    state_reg <= S_PER_GO;
                end
                S_FIT:
                begin
                    if (fit_sum <= aux_reg)
                    begin
                        rel_reg  <= time_reg;
                        ok_reg   <= 1'b1;
                        time_reg <= fit_sum;
                    end
                    state_reg <= S_PER_GO;
                end
                S_UE:
                begin
                    aux_reg   <= aux_reg + ulen_reg;
                    state_reg <= S_UE_GO;
                end
                S_UE_GO:
                begin
                    if (per_reg == '0)
                        state_reg <= S_PER_GO;
                    else
                    begin
                        div_start_reg <= 1'b1;
                        div_num_reg   <= aux_reg;
                        div_den_reg   <= per_reg;
                        state_reg     <= S_UE_WAIT;
                    end
                end
                S_UE_WAIT:
                begin
                    if (div_done)
                        state_reg <= (div_rem == '0) ? S_REL : S_PER_GO;
                end
                S_REL:
                begin
                    rel_reg   <= time_reg;
                    ok_reg    <= 1'b1;
                    time_reg  <= fit_sum;
                    state_reg <= S_PER_GO;
                end
                S_PER_GO:
                begin
                    if (per_reg == '0)
                    begin
                        ps_reg    <= 1'b0;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        div_start_reg <= 1'b1;
                        div_num_reg   <= time_reg;
                        div_den_reg   <= per_reg;
                        state_reg     <= S_PER_WAIT;
                    end
                end
                S_PER_WAIT:
                begin
                    if (div_done)
                    begin
                        ps_reg    <= div_rem == '0;
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (res_take)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb
    begin
        idle             = state_reg == S_IDLE;
        res_valid        = state_reg == S_DONE;
        res.released     = ok_reg;
        res.release_time = FB'(rel_reg);
        res.time_now     = FB'(time_reg);
        res.mode_end     = time_reg == W'(cfg.mode_period);
        res.period_start = ps_reg;
    end

    a_reject_zero_time: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !ok_reg) |-> rel_reg == '0)
        else $error("release time set on a rejected item");

    a_release_on_run: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && ok_reg) |-> cmd_reg == upta_pkg::CMD_RUN)
        else $error("release reported for a non-run command");

    a_nonzero_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        div_start_reg |-> div_den_reg != '0)
        else $error("remainder launched with zero divisor");

    a_time_held_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && !start) |=> $stable(time_reg))
        else $error("model time moved while idle");

endmodule

// ===== src/unit_phase_time_accountant.sv =====
`timescale 1ns / 1ps
// A time-zero or spare command with zero period needs no pass of the bit-serial remainder unit;
// the worst case (output servant) is set by up to four passes of that unit.
// Throughput: one item at a time; the next transfer is taken once the result is registered.
// Reset (rst_n, asynchronous, active low) clears model time to zero, unit_length to 1
// and the other configuration registers to 0; no clearing pass.

module unit_phase_time_accountant #(
    parameter int TICK_BITS = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  upta_pkg::in_item_t                    in_data,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output upta_pkg::out_item_t                   out_data,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [upta_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [upta_pkg::FIELD_BITS-1:0]       cfg_data
);

    upta_pkg::cfg_t      cfg_reg;
    upta_pkg::out_item_t out_data_reg;
    logic                out_valid_reg;

    logic                core_idle;
    logic                res_valid;
    logic                res_take;
    upta_pkg::out_item_t res;

    assign cfg_ready = 1'b1;
    assign in_stall  = !core_idle;
    assign res_take  = res_valid && (!out_valid_reg || !out_stall);

    upta_core #(
        .TICK_BITS (TICK_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_valid && core_idle),
        .item      (in_data),
        .cfg       (cfg_reg),
        .idle      (core_idle),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.unit_length     <= upta_pkg::UNIT_LENGTH_RESET;
            cfg_reg.input_duration  <= '0;
            cfg_reg.output_duration <= '0;
            cfg_reg.mode_period     <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                upta_pkg::REG_UNIT_LENGTH:     cfg_reg.unit_length     <= cfg_data;
                upta_pkg::REG_INPUT_DURATION:  cfg_reg.input_duration  <= cfg_data;
                upta_pkg::REG_OUTPUT_DURATION: cfg_reg.output_duration <= cfg_data;
                upta_pkg::REG_MODE_PERIOD:     cfg_reg.mode_period     <= cfg_data;
                default:                       cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // Output register: load a finished result, drop valid once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
            out_data_reg  <= res;
        end
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== dv/upta_checker.sv =====
`timescale 1ns / 1ps

module upta_checker
    import upta_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  in_item_t                  in_data,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  out_item_t                 out_data,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [FIELD_BITS-1:0]     cfg_data,
    output int                        fail_count,
    output int                        open_count,
    output int                        command_count,
    output int                        release_count
);

    logic [FIELD_BITS-1:0] unit_len_r;
    logic [FIELD_BITS-1:0] in_dur_r;
    logic [FIELD_BITS-1:0] out_dur_r;
    logic [FIELD_BITS-1:0] mode_per_r;
    logic [FIELD_BITS-1:0] tick_now;

    out_item_t predicted_results[$];

    function automatic logic [FIELD_BITS-1:0] unit_size();
        return (unit_len_r == 0) ? FIELD_BITS'(1) : unit_len_r;
    endfunction

    // Units are half-open (start, start + length], so a time on a boundary
    // belongs to the unit that ends there
    function automatic logic [FIELD_BITS-1:0] unit_open(input logic [FIELD_BITS-1:0] t);
        logic [FIELD_BITS-1:0] offs;
        if (t == 0)
            return '0;
        offs = (t - FIELD_BITS'(1)) % unit_size();
        return t - offs - FIELD_BITS'(1);
    endfunction

    function automatic logic [FIELD_BITS-1:0] output_open(input logic [FIELD_BITS-1:0] t);
        logic [FIELD_BITS-1:0] res;
        res = unit_open(t) + unit_size() - out_dur_r;
        return res;
    endfunction

    function automatic bit is_multiple(input logic [FIELD_BITS-1:0] v,
                                       input logic [FIELD_BITS-1:0] p);
        if (p == 0)
            return 1'b0;
        return (v % p) == 0;
    endfunction

    function automatic out_item_t account_step(input in_item_t it);
        out_item_t             res;
        logic [FIELD_BITS-1:0] t;
        logic [FIELD_BITS-1:0] lim;
        logic [FIELD_BITS-1:0] fin;
        logic [FIELD_BITS-1:0] unit_end;
        res = '0;
        t = tick_now;
        case (it.command)
            CMD_RUN:
            begin
                if (it.servant_kind == KIND_INPUT)
                begin
                    res.released = 1'b1;
                    res.release_time = t;
                    t = t + it.exec_ticks;
                end
                else if (it.servant_kind == KIND_COMPUTE)
                begin
                    lim = unit_open(t) + in_dur_r;
                    if (t < lim)
                        t = lim;
                    fin = t + it.exec_ticks;
                    // reject if it would overrun the output phase; keep the raised time
                    if (fin <= output_open(t))
                    begin
                        res.released = 1'b1;
                        res.release_time = t;
                        t = fin;
                    end
                end
                else
                begin
                    lim = output_open(t);
                    if (t < lim)
                        t = lim;
                    unit_end = output_open(t) + out_dur_r;
                    if (is_multiple(unit_end, it.task_period))
                    begin
                        res.released = 1'b1;
                        res.release_time = t;
                        t = t + it.exec_ticks;
                    end
                end
            end
            CMD_NEXT_UNIT:
                t = unit_open(t) + unit_size();
            CMD_TIME_ZERO:
                t = '0;
            default:
                ;
        endcase
        tick_now = t;
        res.time_now = t;
        res.mode_end = (t == mode_per_r);
        res.period_start = is_multiple(t, it.task_period);
        return res;
    endfunction

    task automatic check_field(input string name, input logic [FIELD_BITS-1:0] exp_v,
                               input logic [FIELD_BITS-1:0] act_v);
        if (exp_v !== act_v)
        begin
            fail_count++;
            $display("%t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            unit_len_r = UNIT_LENGTH_RESET;
            in_dur_r = '0;
            out_dur_r = '0;
            mode_per_r = '0;
            tick_now = '0;
            predicted_results.delete();
            fail_count = 0;
            command_count = 0;
            release_count = 0;
            open_count <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_UNIT_LENGTH:     unit_len_r = cfg_data;
                    REG_INPUT_DURATION:  in_dur_r = cfg_data;
                    REG_OUTPUT_DURATION: out_dur_r = cfg_data;
                    REG_MODE_PERIOD:     mode_per_r = cfg_data;
                    default:             ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                predicted_results.push_back(account_step(in_data));
                command_count++;
            end
            if (out_valid && !out_stall)
            begin
                if (predicted_results.size() == 0)
                begin
                    fail_count++;
                    $display("%t: result with nothing outstanding: expected none, actual %h",
                             $time, out_data);
                end
                else
                begin
                    want = predicted_results.pop_front();
                    if (out_data.released === 1'b1)
                        release_count++;
                    check_field("released", FIELD_BITS'(want.released),
                                FIELD_BITS'(out_data.released));
                    check_field("release_time", want.release_time, out_data.release_time);
                    check_field("time_now", want.time_now, out_data.time_now);
                    check_field("mode_end", FIELD_BITS'(want.mode_end),
                                FIELD_BITS'(out_data.mode_end));
                    check_field("period_start", FIELD_BITS'(want.period_start),
                                FIELD_BITS'(out_data.period_start));
                end
            end
            open_count <= predicted_results.size();
        end
    end

endmodule

// ===== dv/unit_phase_time_accountant_tb.sv =====
`timescale 1ns / 1ps

module unit_phase_time_accountant_tb;
    import upta_pkg::*;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 4 * FIELD_BITS + 40;
    localparam int HOLD_CYCLES   = 400;

    // spare codes, not named in the package
    localparam logic [1:0] CMD_SPARE  = 2'd3;
    localparam logic [1:0] KIND_SPARE = 2'd3;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    in_item_t                  in_data = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    out_item_t                 out_data;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [FIELD_BITS-1:0]     cfg_data = '0;

    int fail_count;
    int open_count;
    int command_count;
    int release_count;
    int stall_pct = 0;
    bit long_hold = 1'b0;
    int setting_count = 0;
    int cycle_count = 0;

    unit_phase_time_accountant uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    upta_checker accountant_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_data      (out_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .open_count    (open_count),
        .command_count (command_count),
        .release_count (release_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        out_stall <= long_hold || ($urandom_range(99) < stall_pct);

    function automatic in_item_t make_item(input logic [1:0] c, input logic [1:0] k,
                                           input logic [FIELD_BITS-1:0] x,
                                           input logic [FIELD_BITS-1:0] p);
        in_item_t it;
        it.command = c;
        it.servant_kind = k;
        it.exec_ticks = x;
        it.task_period = p;
        return it;
    endfunction

    // Mostly run commands with execution times well inside a unit and
    // periods tied to the unit length, so that servants land in every phase
    function automatic in_item_t random_item(input logic [FIELD_BITS-1:0] unit);
        longint unsigned       u;
        int                    pick;
        logic [1:0]            c;
        logic [1:0]            k;
        logic [FIELD_BITS-1:0] x;
        logic [FIELD_BITS-1:0] p;
        u = (unit == 0) ? 1 : unit;
        pick = $urandom_range(99);
        c = (pick < 65) ? CMD_RUN : (pick < 88) ? CMD_NEXT_UNIT :
            (pick < 95) ? CMD_TIME_ZERO : CMD_SPARE;
        pick = $urandom_range(9);
        k = (pick < 3) ? KIND_INPUT : (pick < 6) ? KIND_COMPUTE :
            (pick < 9) ? KIND_OUTPUT : KIND_SPARE;
        pick = $urandom_range(9);
        if (pick < 6)
            x = FIELD_BITS'($urandom % (u / 4 + 1));
        else if (pick < 9)
            x = FIELD_BITS'($urandom % (u + 1));
        else
            x = $urandom;
        pick = $urandom_range(9);
        case (pick)
            0:       p = '0;
            1:       p = 1;
            2, 3, 4: p = FIELD_BITS'(u >> $urandom_range(2));
            5:       p = FIELD_BITS'(u * 2);
            6, 7:    p = $urandom_range(16, 1);
            8:       p = $urandom;
            default: p = FIELD_BITS'(u * $urandom_range(4, 1));
        endcase
        return make_item(c, k, x, p);
    endfunction

    // Call at a rising edge; returns at the edge of the transfer
    task automatic send_item(input in_item_t it, input int gap_pct);
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_data <= it;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic settle();
        while (open_count != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Hold valid high across all four writes
    task automatic load_config(input logic [FIELD_BITS-1:0] ul, input logic [FIELD_BITS-1:0] idur,
                               input logic [FIELD_BITS-1:0] odur,
                               input logic [FIELD_BITS-1:0] mper);
        logic [FIELD_BITS-1:0]     vals[4];
        logic [CFG_INDEX_BITS-1:0] idx[4];
        vals = '{ul, idur, odur, mper};
        idx = '{REG_UNIT_LENGTH, REG_INPUT_DURATION, REG_OUTPUT_DURATION, REG_MODE_PERIOD};
        for (int i = 0; i < 4; i++)
        begin
            cfg_index <= idx[i];
            cfg_data <= vals[i];
            cfg_valid <= 1'b1;
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        setting_count++;
    endtask

    task automatic run_phase(input logic [FIELD_BITS-1:0] ul, input logic [FIELD_BITS-1:0] idur,
                             input logic [FIELD_BITS-1:0] odur,
                             input logic [FIELD_BITS-1:0] mper,
                             input int gap_pct, input int stall_new, input int count,
                             input bit with_hold);
        settle();
        load_config(ul, idur, odur, mper);
        stall_pct <= stall_new;
        if (with_hold)
        begin
            // starve the output so the block fills up and stalls its input
            fork
                begin
                    long_hold <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge clk);
                    long_hold <= 1'b0;
                end
            join_none
        end
        for (int i = 0; i < count; i++)
            send_item(random_item(ul), gap_pct);
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[unit_phase_time_accountant] ERROR");
        $finish;
    end

    initial
    begin
        in_item_t script[$];
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values first
        for (int i = 0; i < 40; i++)
            send_item(random_item(UNIT_LENGTH_RESET), 0);
        in_valid <= 1'b0;
        @(posedge clk);

        settle();
        load_config(10, 3, 2, 20);
        script.push_back(make_item(CMD_RUN, KIND_INPUT, 0, 0));
        script.push_back(make_item(CMD_RUN, KIND_INPUT, 4, 2));
        script.push_back(make_item(CMD_RUN, KIND_COMPUTE, 1, 5));
        script.push_back(make_item(CMD_RUN, KIND_COMPUTE, 10, 5));
        script.push_back(make_item(CMD_RUN, KIND_OUTPUT, 1, 10));
        script.push_back(make_item(CMD_RUN, KIND_OUTPUT, 0, 3));
        script.push_back(make_item(CMD_NEXT_UNIT, KIND_INPUT, 0, 10));
        script.push_back(make_item(CMD_NEXT_UNIT, KIND_INPUT, 0, 10));
        script.push_back(make_item(CMD_RUN, KIND_INPUT, 1, 0));
        script.push_back(make_item(CMD_NEXT_UNIT, KIND_OUTPUT, 0, 4));
        script.push_back(make_item(CMD_RUN, KIND_COMPUTE, 0, 0));
        script.push_back(make_item(CMD_RUN, KIND_SPARE, 0, 0));
        script.push_back(make_item(CMD_SPARE, KIND_OUTPUT, '1, '1));
        script.push_back(make_item(CMD_TIME_ZERO, KIND_COMPUTE, 0, 7));
        script.push_back(make_item(CMD_RUN, KIND_INPUT, '1, '1));
        script.push_back(make_item(CMD_RUN, KIND_INPUT, 1, 1));
        script.push_back(make_item(CMD_RUN, KIND_COMPUTE, '1, 0));
        script.push_back(make_item(CMD_RUN, KIND_OUTPUT, '1, 1));
        script.push_back(make_item(CMD_RUN, KIND_INPUT, 32'h8000_0000, 32'h8000_0000));
        script.push_back(make_item(CMD_NEXT_UNIT, KIND_SPARE, 0, '1));
        script.push_back(make_item(CMD_TIME_ZERO, KIND_INPUT, 0, 0));
        foreach (script[i])
            send_item(script[i], 0);
        in_valid <= 1'b0;
        @(posedge clk);

        run_phase(10, 3, 2, 20, 55, 0, 250, 1'b0);
        run_phase(1000, 100, 200, 3000, 0, 55, 250, 1'b1);
        run_phase(0, 0, 0, 0, 23, 23, 120, 1'b0);
        run_phase('1, '1, '1, '1, 0, 0, 120, 1'b0);
        run_phase(16, 20, 0, 48, 23, 23, 200, 1'b0);
        run_phase(7, 2, 3, 14, 0, 0, 250, 1'b1);
        settle();

        $display("Covered %0d commands under %0d register settings plus reset values;",
                 command_count, setting_count);
        $display("%0d servants were released, the rest rejected or non-run.", release_count);
        if (fail_count == 0)
            $display("[unit_phase_time_accountant] OK");
        else
            $display("[unit_phase_time_accountant] ERROR");
        $finish;
    end

endmodule
